>>> rtl/planar_odometry_integrator_top_macros.svh
// Assertion macros used by the odometry integrator top level.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_TOP_MACROS_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_TOP_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define POI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define POI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/poi_pkg.sv
// Types, constants and helper functions of the odometry integrator.
package poi_pkg;

    localparam int DIGIT_W      = 4;
    localparam int VEL_W        = 16;
    localparam int DT_W         = 16;
    localparam int POS_W        = 32;
    localparam int HEAD_W       = 16;
    localparam int CORDIC_W     = 32;
    localparam int ATAN_IDX_W   = 5;
    localparam int LANE_MCAND_W = 34;
    localparam int LANE_ACC_W   = 51;
    localparam int HEAD_MCAND_W = 32;
    localparam int HEAD_ACC_W   = 63;
    localparam int TURN_W       = 32;
    localparam int ROT_SHIFT    = 14;
    localparam int DT_SHIFT     = 28;
    localparam int HEAD_SHIFT   = 60;
    localparam int DX_W         = LANE_ACC_W - DT_SHIFT;
    localparam int SUM_W        = POS_W + 2;
    localparam int MUL_A_DIGITS = VEL_W / DIGIT_W;
    localparam int MUL_B_DIGITS = TURN_W / DIGIT_W;
    localparam int LANE_B_DIGITS = DT_W / DIGIT_W;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;
    // 2^32 / (2 pi), rounded
    localparam logic [TURN_W-1:0] TURN_PER_RAD = 32'd683565276;
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_MUL_A,
        ST_ROUND,
        ST_MUL_B,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                  load;
        logic                  step;
        logic [ATAN_IDX_W-1:0] idx;
    } cordic_ctl_t;

    typedef struct packed {
        logic en;
        logic clr;
    } mac_ctl_t;

    // arctan(2^-i) in units of 2^-32 turn
    function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        case (idx)
            5'd0:    atan_turn = 32'sd536870912;
            5'd1:    atan_turn = 32'sd316933406;
            5'd2:    atan_turn = 32'sd167458907;
            5'd3:    atan_turn = 32'sd85004756;
            5'd4:    atan_turn = 32'sd42667331;
            5'd5:    atan_turn = 32'sd21354465;
            5'd6:    atan_turn = 32'sd10679838;
            5'd7:    atan_turn = 32'sd5340245;
            5'd8:    atan_turn = 32'sd2670163;
            5'd9:    atan_turn = 32'sd1335087;
            5'd10:   atan_turn = 32'sd667544;
            5'd11:   atan_turn = 32'sd333772;
            5'd12:   atan_turn = 32'sd166886;
            5'd13:   atan_turn = 32'sd83443;
            5'd14:   atan_turn = 32'sd41722;
            5'd15:   atan_turn = 32'sd20861;
            5'd16:   atan_turn = 32'sd10430;
            5'd17:   atan_turn = 32'sd5215;
            5'd18:   atan_turn = 32'sd2608;
            5'd19:   atan_turn = 32'sd1304;
            5'd20:   atan_turn = 32'sd652;
            5'd21:   atan_turn = 32'sd326;
            5'd22:   atan_turn = 32'sd163;
            5'd23:   atan_turn = 32'sd81;
            default: atan_turn = '0;
        endcase
    endfunction

    // radix-16 digit; the top digit of a signed operand carries the sign
    function automatic logic signed [DIGIT_W:0] digit_of(input logic [DIGIT_W-1:0] nib,
                                                         input logic sgn);
        digit_of = sgn ? {nib[DIGIT_W-1], nib} : {1'b0, nib};
    endfunction

    // returns {clip, sum}
    function automatic logic [POS_W:0] sat_add(input logic signed [POS_W-1:0] a,
                                               input logic signed [DX_W-1:0] d);
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(d);
        if (s > SUM_W'(POS_MAX)) begin
            sat_add = {1'b1, POS_MAX};
        end else if (s < SUM_W'(POS_MIN)) begin
            sat_add = {1'b1, POS_MIN};
        end else begin
            sat_add = {1'b0, s[POS_W-1:0]};
        end
    endfunction

endpackage

>>> rtl/poi_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle while step is asserted.
module poi_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                                  aclk,
    input  poi_pkg::cordic_ctl_t                  ctl,
    input  logic [ANGLE_BITS-1:0]                 angle,
    output logic signed [poi_pkg::CORDIC_W-1:0]   cos_out,
    output logic signed [poi_pkg::CORDIC_W-1:0]   sin_out
);
    import poi_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg, y_reg, z_reg;
    logic signed [CORDIC_W-1:0] x_next, y_next, z_next;
    logic                       flip_reg, flip_next;
    logic [CORDIC_W-1:0]        a32;
    logic                       flip_in;
    logic signed [CORDIC_W-1:0] xs, ys, atan_i;

    assign a32     = {angle, {(CORDIC_W-ANGLE_BITS){1'b0}}};
    // outside [-1/4, 1/4) turn: take off half a turn, negate at the end
    assign flip_in = a32[CORDIC_W-1] ^ a32[CORDIC_W-2];
    assign xs      = x_reg >>> ctl.idx;
    assign ys      = y_reg >>> ctl.idx;
    assign atan_i  = atan_turn(ctl.idx);

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        flip_next = flip_reg;
        if (ctl.load) begin
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = {a32[CORDIC_W-1] ^ flip_in, a32[CORDIC_W-2:0]};
            flip_next = flip_in;
        end else if (ctl.step) begin
            if (!z_reg[CORDIC_W-1]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_i;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_i;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;

endmodule

>>> rtl/poi_mac.sv
// Digit-serial multiply-accumulate, one radix-16 digit per cycle while en is asserted, MSB first.
module poi_mac #(
    parameter int MCAND_W = 34,
    parameter int ACC_W   = 51
) (
    input  logic                               aclk,
    input  poi_pkg::mac_ctl_t                  ctl,
    input  logic signed [MCAND_W-1:0]          mcand0,
    input  logic signed [poi_pkg::DIGIT_W:0]   digit0,
    input  logic signed [MCAND_W-1:0]          mcand1,
    input  logic signed [poi_pkg::DIGIT_W:0]   digit1,
    output logic signed [ACC_W-1:0]            acc
);
    import poi_pkg::*;

    logic signed [MCAND_W+DIGIT_W:0] prod0, prod1;
    logic signed [ACC_W-1:0]         acc_reg, acc_next, base;

    assign prod0 = mcand0 * digit0;
    assign prod1 = mcand1 * digit1;

    always_comb begin
        base     = ctl.clr ? '0 : (acc_reg <<< DIGIT_W);
        acc_next = base + ACC_W'(prod0) + ACC_W'(prod1);
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

>>> rtl/planar_odometry_integrator_top.sv
// Dead-reckoning pose integrator for a holonomic base. Each item carries body
// velocity x/y, yaw rate and elapsed time; the velocity is rotated by the
// stored heading (CORDIC), scaled by elapsed time and added to the saturating
// Q16.16 position, and the binary-angle heading advances modulo one turn. One
// result per item. After acceptance an item passes through the iterative
// CORDIC (CORDIC_STEPS micro-rotations), the radix-16 serial multipliers on
// the velocity digits, rounding, the second multiplier pass (the heading term
// takes eight digits of the turn factor) and write-back, which waits while
// the output is blocked; only then is the next item accepted. A finished
// result waits in the output register while the next item is accepted.
`include "planar_odometry_integrator_top_macros.svh"

module planar_odometry_integrator_top #(
    parameter int CORDIC_STEPS = 16,
    parameter int ANGLE_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // vel_x, vel_y, yaw_rate, elapsed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // pos_x, pos_y, heading, saturated, zero pad
);
    import poi_pkg::*;

    localparam int CNT_W   = $clog2(CORDIC_STEPS);
    localparam int OUT_F_W = 2 * POS_W + HEAD_W + 1;
    localparam int OUT_W   = ((OUT_F_W + 7) / 8) * 8;

    localparam logic signed [LANE_ACC_W-1:0] HALF_ROT = LANE_ACC_W'(1) <<< (ROT_SHIFT - 1);
    localparam logic signed [LANE_ACC_W-1:0] HALF_DT  = LANE_ACC_W'(1) <<< (DT_SHIFT - 1);
    localparam logic signed [HEAD_ACC_W-1:0] HALF_HD  =
        HEAD_ACC_W'(1) <<< (HEAD_SHIFT - ANGLE_BITS - 1);

    state_t                         state_reg, state_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [VEL_W-1:0]               vx_sh_reg, vy_sh_reg;
    logic [DT_W-1:0]                dt_sh_reg, dt_reg;
    logic signed [VEL_W-1:0]        w_reg;
    logic [TURN_W-1:0]              k_sh_reg;
    logic signed [LANE_MCAND_W-1:0] rx_reg, ry_reg;
    logic signed [HEAD_MCAND_W-1:0] t_reg;
    logic signed [POS_W-1:0]        world_x_reg, world_y_reg;
    logic [ANGLE_BITS-1:0]          yaw_reg;
    logic                           m_tvalid_reg;
    logic signed [POS_W-1:0]        out_x_reg, out_y_reg;
    logic [HEAD_W-1:0]              out_head_reg;
    logic                           out_sat_reg;

    logic        accept, shift_a, do_round, shift_b, out_load, phase_b, first_a;
    cordic_ctl_t cordic_ctl;
    mac_ctl_t    lane_ctl, head_ctl;

    logic signed [CORDIC_W-1:0]     cos_val, sin_val;
    logic signed [DIGIT_W:0]        dvx, dvy, ddt, dk, lane_d0, lane_d1, head_d0;
    logic signed [LANE_MCAND_W-1:0] cos_ext, sin_ext, x_m0, x_m1, y_m0;
    logic signed [HEAD_MCAND_W-1:0] head_m0;
    logic signed [LANE_ACC_W-1:0]   acc_x, acc_y, rnd_x, rnd_y, fin_x, fin_y;
    logic signed [HEAD_ACC_W-1:0]   acc_h, fin_h;
    logic [POS_W:0]                 sat_x, sat_y;
    logic [ANGLE_BITS-1:0]          yaw_new;
    logic [HEAD_W-1:0]              head16;

    // control
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        accept     = 1'b0;
        shift_a    = 1'b0;
        do_round   = 1'b0;
        shift_b    = 1'b0;
        out_load   = 1'b0;
        cordic_ctl = '{load: 1'b0, step: 1'b0, idx: ATAN_IDX_W'(cnt_reg)};
        lane_ctl   = '{en: 1'b0, clr: 1'b0};
        head_ctl   = '{en: 1'b0, clr: 1'b0};
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    accept          = 1'b1;
                    cordic_ctl.load = 1'b1;
                    cnt_next        = '0;
                    state_next      = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                cordic_ctl.step = 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_MUL_A;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL_A: begin
                shift_a  = 1'b1;
                lane_ctl = '{en: 1'b1, clr: (cnt_reg == '0)};
                head_ctl = '{en: 1'b1, clr: (cnt_reg == '0)};
                if (cnt_reg == CNT_W'(MUL_A_DIGITS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_ROUND;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROUND: begin
                do_round   = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                shift_b  = 1'b1;
                lane_ctl = '{en: (cnt_reg < CNT_W'(LANE_B_DIGITS)), clr: (cnt_reg == '0)};
                head_ctl = '{en: 1'b1, clr: (cnt_reg == '0)};
                if (cnt_reg == CNT_W'(MUL_B_DIGITS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // digit shift registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            vx_sh_reg <= s_tdata[VEL_W-1:0];
            vy_sh_reg <= s_tdata[2*VEL_W-1:VEL_W];
            w_reg     <= s_tdata[3*VEL_W-1:2*VEL_W];
            dt_reg    <= s_tdata[3*VEL_W+DT_W-1:3*VEL_W];
            dt_sh_reg <= s_tdata[3*VEL_W+DT_W-1:3*VEL_W];
        end else if (shift_a) begin
            vx_sh_reg <= vx_sh_reg << DIGIT_W;
            vy_sh_reg <= vy_sh_reg << DIGIT_W;
            dt_sh_reg <= dt_sh_reg << DIGIT_W;
        end else if (do_round) begin
            dt_sh_reg <= dt_reg;
            k_sh_reg  <= TURN_PER_RAD;
            rx_reg    <= rnd_x[ROT_SHIFT+LANE_MCAND_W-1:ROT_SHIFT];
            ry_reg    <= rnd_y[ROT_SHIFT+LANE_MCAND_W-1:ROT_SHIFT];
            t_reg     <= acc_h[HEAD_MCAND_W-1:0];
        end else if (shift_b) begin
            dt_sh_reg <= dt_sh_reg << DIGIT_W;
            k_sh_reg  <= k_sh_reg << DIGIT_W;
        end
    end

    assign phase_b = (state_reg == ST_MUL_B);
    assign first_a = (cnt_reg == '0);
    assign dvx     = digit_of(vx_sh_reg[VEL_W-1 -: DIGIT_W], first_a);
    assign dvy     = digit_of(vy_sh_reg[VEL_W-1 -: DIGIT_W], first_a);
    assign ddt     = digit_of(dt_sh_reg[DT_W-1 -: DIGIT_W], 1'b0);
    assign dk      = digit_of(k_sh_reg[TURN_W-1 -: DIGIT_W], 1'b0);

    assign cos_ext = LANE_MCAND_W'(cos_val);
    assign sin_ext = LANE_MCAND_W'(sin_val);
    assign x_m0    = phase_b ? rx_reg : cos_ext;
    assign x_m1    = -sin_ext;
    assign y_m0    = phase_b ? ry_reg : sin_ext;
    assign lane_d0 = phase_b ? ddt : dvx;
    assign lane_d1 = phase_b ? '0 : dvy;
    assign head_m0 = phase_b ? t_reg : HEAD_MCAND_W'(w_reg);
    assign head_d0 = phase_b ? dk : ddt;

    poi_cordic #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_cordic (
        .aclk    (aclk),
        .ctl     (cordic_ctl),
        .angle   (yaw_reg),
        .cos_out (cos_val),
        .sin_out (sin_val)
    );

    poi_mac #(
        .MCAND_W(LANE_MCAND_W),
        .ACC_W  (LANE_ACC_W)
    ) u_mac_x (
        .aclk   (aclk),
        .ctl    (lane_ctl),
        .mcand0 (x_m0),
        .digit0 (lane_d0),
        .mcand1 (x_m1),
        .digit1 (lane_d1),
        .acc    (acc_x)
    );

    poi_mac #(
        .MCAND_W(LANE_MCAND_W),
        .ACC_W  (LANE_ACC_W)
    ) u_mac_y (
        .aclk   (aclk),
        .ctl    (lane_ctl),
        .mcand0 (y_m0),
        .digit0 (lane_d0),
        .mcand1 (cos_ext),
        .digit1 (lane_d1),
        .acc    (acc_y)
    );

    poi_mac #(
        .MCAND_W(HEAD_MCAND_W),
        .ACC_W  (HEAD_ACC_W)
    ) u_mac_h (
        .aclk   (aclk),
        .ctl    (head_ctl),
        .mcand0 (head_m0),
        .digit0 (head_d0),
        .mcand1 ('0),
        .digit1 ('0),
        .acc    (acc_h)
    );

    // rounding and write-back
    assign rnd_x   = acc_x + HALF_ROT;
    assign rnd_y   = acc_y + HALF_ROT;
    assign fin_x   = acc_x + HALF_DT;
    assign fin_y   = acc_y + HALF_DT;
    assign fin_h   = acc_h + HALF_HD;
    assign sat_x   = sat_add(world_x_reg, fin_x[LANE_ACC_W-1:DT_SHIFT]);
    assign sat_y   = sat_add(world_y_reg, fin_y[LANE_ACC_W-1:DT_SHIFT]);
    assign yaw_new = yaw_reg + fin_h[HEAD_SHIFT-1 -: ANGLE_BITS];

    generate
        if (ANGLE_BITS >= HEAD_W) begin : g_head_trunc
            assign head16 = yaw_new[ANGLE_BITS-1 -: HEAD_W];
        end else begin : g_head_pad
            assign head16 = {yaw_new, {(HEAD_W-ANGLE_BITS){1'b0}}};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            world_x_reg  <= '0;
            world_y_reg  <= '0;
            yaw_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                world_x_reg  <= sat_x[POS_W-1:0];
                world_y_reg  <= sat_y[POS_W-1:0];
                yaw_reg      <= yaw_new;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_x_reg    <= sat_x[POS_W-1:0];
            out_y_reg    <= sat_y[POS_W-1:0];
            out_head_reg <= head16;
            out_sat_reg  <= sat_x[POS_W] | sat_y[POS_W];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_W-OUT_F_W){1'b0}}, out_sat_reg, out_head_reg,
                       out_y_reg, out_x_reg};

    `POI_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_reg == ST_CORDIC, "item accepted but CORDIC not started")
    `POI_ASSERT_NEXT(a_finish_holds, (state_reg == ST_FINISH) && m_tvalid_reg && !m_tready, (state_reg == ST_FINISH) && m_tvalid_reg, "finished item dropped while output blocked")
    `POI_ASSERT_SAME(a_sat_at_limit, m_tvalid_reg && out_sat_reg, (out_x_reg == POS_MAX) || (out_x_reg == POS_MIN) || (out_y_reg == POS_MAX) || (out_y_reg == POS_MIN), "saturated flag without clipped position")
    `POI_ASSERT_SAME(a_out_matches_state, m_tvalid_reg, (out_x_reg == world_x_reg) && (out_y_reg == world_y_reg), "held result differs from stored position")

endmodule
